// ===== src/rsc_pkg.sv =====
// Shared types, codes and constants of the reverse Polish stack calculator.
`default_nettype none
package rsc_pkg;

	localparam int DATA_W          = 32;
	localparam int FRAC_W          = 16;
	localparam int ENTRIES_W       = 7;
	localparam int STACK_DEPTH_DEF = 64;
	localparam int DIV_NUM_W       = DATA_W + FRAC_W;

	localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

	typedef enum logic [2:0] {
		OP_PUSH = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4,
		OP_PEEK = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_SAT   = 2'd3
	} stat_t;

	typedef struct packed {
		logic [2:0]               operation;
		logic signed [DATA_W-1:0] operand;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		stat_t                    status;
		logic [ENTRIES_W-1:0]     entries;
	} rsp_t;

	typedef struct packed {
		logic                     done;
		logic                     sat;
		logic signed [DATA_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_DIV
	} state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_RUN,
		DV_DONE
	} dv_state_t;

endpackage
`default_nettype wire

// ===== src/rsc_divider.sv =====
// Bit-serial signed Q16.16 divider with saturation of the quotient.
`default_nettype none
module rsc_divider (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic signed [rsc_pkg::DATA_W-1:0] dividend,
	input  wire logic signed [rsc_pkg::DATA_W-1:0] divisor,
	output rsc_pkg::div_rsp_t                     rsp
);
	import rsc_pkg::*;

	localparam int CNT_W = $clog2(DIV_NUM_W);

	dv_state_t                state_q, state_d;
	logic [CNT_W-1:0]         cnt_q;
	logic [DIV_NUM_W-1:0]     num_q;
	logic [DATA_W-1:0]        rem_q;
	logic [DATA_W-1:0]        den_q;
	logic                     neg_q;
	logic                     done_q;
	logic                     sat_q;
	logic signed [DATA_W-1:0] quot_q;

	logic [DATA_W:0]      trial;
	logic                 ge;
	logic [DATA_W-1:0]    dvd_mag;
	logic [DATA_W-1:0]    dvs_mag;
	logic                 ovf_neg;
	logic                 ovf_pos;

	assign dvd_mag = dividend[DATA_W-1] ? DATA_W'(-dividend) : DATA_W'(dividend);
	assign dvs_mag = divisor[DATA_W-1] ? DATA_W'(-divisor) : DATA_W'(divisor);
	assign trial   = {rem_q, num_q[DIV_NUM_W-1]};
	assign ge      = trial >= {1'b0, den_q};

	assign ovf_neg = (|num_q[DIV_NUM_W-1:DATA_W]) ||
		(num_q[DATA_W-1] && (|num_q[DATA_W-2:0]));
	assign ovf_pos = |num_q[DIV_NUM_W-1:DATA_W-1];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DV_IDLE: begin
				if (start) begin
					state_d = DV_RUN;
				end
			end
			DV_RUN: begin
				if (cnt_q == '0) begin
					state_d = DV_DONE;
				end
			end
			DV_DONE: begin
				state_d = DV_IDLE;
			end
			default: begin
				state_d = DV_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == DV_DONE);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			DV_IDLE: begin
				num_q <= {dvd_mag, FRAC_W'(0)};
				rem_q <= '0;
				den_q <= dvs_mag;
				neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
				cnt_q <= CNT_W'(DIV_NUM_W - 1);
			end
			DV_RUN: begin
				rem_q <= ge ? DATA_W'(trial - {1'b0, den_q}) : trial[DATA_W-1:0];
				num_q <= {num_q[DIV_NUM_W-2:0], ge};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			DV_DONE: begin
				if (neg_q) begin
					sat_q  <= ovf_neg;
					quot_q <= ovf_neg ? Q_MIN : DATA_W'(-num_q[DATA_W-1:0]);
				end else begin
					sat_q  <= ovf_pos;
					quot_q <= ovf_pos ? Q_MAX : num_q[DATA_W-1:0];
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign rsp = '{done: done_q, sat: sat_q, quotient: quot_q};

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == DV_IDLE)
		else $error("divider started while running");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == DV_RUN |-> den_q != '0)
		else $error("divider running on a zero divisor");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held for more than one cycle");

endmodule
`default_nettype wire

// ===== src/rpn_stack_calculator_unit.sv =====
// Top level of the reverse Polish stack calculator with its operand stack memory.
//
// A request is taken when start is high and busy is low; each request gives exactly one
// result, shown for one cycle with done high, and the receiver cannot stall it. Push, peek,
// unused codes and every request that fails for lack of entries or room answer in the cycle
// after acceptance; add and subtract finish in the execute state, multiply in the state
// after it, divide when the divider, at one of 48 quotient bits per cycle, is done. The
// stack lives in a single-port synchronous memory; the top entry is mirrored in a register
// so a binary operation needs only one read, of the entry below the top, at acceptance.
`default_nettype none
module rpn_stack_calculator_unit #(
	parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output      logic          busy,
	input  wire rsc_pkg::req_t request,
	output      logic          done,
	output      rsc_pkg::rsp_t result
);
	import rsc_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	logic [DATA_W-1:0] mem [STACK_DEPTH];

	state_t                     state_q, state_d;
	logic [CW-1:0]              count_q, count_d;
	logic signed [DATA_W-1:0]   top_q, top_d;
	logic [2:0]                 op_q;
	logic signed [DATA_W-1:0]   rdata_q;
	logic signed [2*DATA_W-1:0] prod_q;
	rsp_t                       rsp_q, rsp_d;
	logic                       done_q, done_d;

	logic                       mem_we;
	logic [AW-1:0]              mem_wa;
	logic [DATA_W-1:0]          mem_wd;
	logic                       mem_re;
	logic [AW-1:0]              below_addr;

	logic signed [DATA_W-1:0]   top_val;
	logic [DATA_W:0]            sum;
	logic [DATA_W:0]            diff;
	logic [DATA_W:0]            addsub;
	logic signed [2*DATA_W-1:0] shifted;
	logic                       fin;
	logic                       fin_sat;
	logic signed [DATA_W-1:0]   fin_val;
	logic                       div_start;
	div_rsp_t                   div_rsp;

	assign top_val    = (count_q != '0) ? top_q : '0;
	assign below_addr = AW'(count_q - CW'(2));
	assign sum        = {top_q[DATA_W-1], top_q} + {rdata_q[DATA_W-1], rdata_q};
	assign diff       = {rdata_q[DATA_W-1], rdata_q} - {top_q[DATA_W-1], top_q};
	assign addsub     = (op_q == OP_SUB) ? diff : sum;
	assign shifted    = prod_q >>> FRAC_W;

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		top_d         = top_q;
		rsp_d         = rsp_q;
		done_d        = 1'b0;
		mem_we        = 1'b0;
		mem_wa        = below_addr;
		mem_wd        = '0;
		mem_re        = 1'b0;
		div_start     = 1'b0;
		fin           = 1'b0;
		fin_sat       = 1'b0;
		fin_val       = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					done_d        = 1'b1;
					rsp_d.value   = top_val;
					rsp_d.status  = STAT_OK;
					rsp_d.entries = ENTRIES_W'(count_q);
					unique case (request.operation) inside
						OP_PUSH: begin
							if (count_q == CW'(STACK_DEPTH)) begin
								rsp_d.status = STAT_FULL;
							end else begin
								mem_we        = 1'b1;
								mem_wa        = AW'(count_q);
								mem_wd        = request.operand;
								top_d         = request.operand;
								count_d       = count_q + CW'(1);
								rsp_d.value   = request.operand;
								rsp_d.entries = ENTRIES_W'(count_q + CW'(1));
							end
						end
						OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
							if (count_q < CW'(2)) begin
								rsp_d.status = STAT_EMPTY;
							end else begin
								done_d  = 1'b0;
								mem_re  = 1'b1;
								state_d = ST_EXEC;
							end
						end
						OP_PEEK: begin
							if (count_q == '0) begin
								rsp_d.status = STAT_EMPTY;
							end
						end
						default: begin
							rsp_d.status = STAT_OK;
						end
					endcase
				end
			end
			ST_EXEC: begin
				unique case (op_q) inside
					OP_ADD, OP_SUB: begin
						fin     = 1'b1;
						fin_sat = addsub[DATA_W] != addsub[DATA_W-1];
						fin_val = fin_sat ? (addsub[DATA_W] ? Q_MIN : Q_MAX)
							: addsub[DATA_W-1:0];
					end
					OP_MUL: begin
						state_d = ST_MUL;
					end
					OP_DIV: begin
						if (top_q == '0) begin
							fin     = 1'b1;
							fin_sat = 1'b1;
							fin_val = rdata_q[DATA_W-1] ? Q_MIN : Q_MAX;
						end else begin
							div_start = 1'b1;
							state_d   = ST_DIV;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_MUL: begin
				fin     = 1'b1;
				fin_sat = !((&shifted[2*DATA_W-1:DATA_W-1]) ||
					(~|shifted[2*DATA_W-1:DATA_W-1]));
				fin_val = fin_sat ? (shifted[2*DATA_W-1] ? Q_MIN : Q_MAX)
					: shifted[DATA_W-1:0];
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					fin     = 1'b1;
					fin_sat = div_rsp.sat;
					fin_val = div_rsp.quotient;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (fin) begin
			state_d       = ST_IDLE;
			mem_we        = 1'b1;
			mem_wa        = below_addr;
			mem_wd        = fin_val;
			top_d         = fin_val;
			count_d       = count_q - CW'(1);
			done_d        = 1'b1;
			rsp_d.value   = fin_val;
			rsp_d.status  = fin_sat ? STAT_SAT : STAT_OK;
			rsp_d.entries = ENTRIES_W'(count_q - CW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		top_q  <= top_d;
		rsp_q  <= rsp_d;
		prod_q <= top_q * rdata_q;
		if (state_q == ST_IDLE) begin
			op_q <= request.operation;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= mem[below_addr];
		end
	end

	rsc_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rdata_q),
		.divisor  (top_q),
		.rsp      (div_rsp)
	);

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign result = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_bin_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && count_q >= CW'(2) &&
		(request.operation == OP_ADD || request.operation == OP_SUB ||
		request.operation == OP_MUL || request.operation == OP_DIV))
		|=> state_q == ST_EXEC)
		else $error("binary operation did not enter execution");

	a_full_entries: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == STAT_FULL) |-> result.entries == ENTRIES_W'(STACK_DEPTH))
		else $error("full status reported on a stack with room");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> count_q >= CW'(2))
		else $error("division running with fewer than two entries");

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench of the reverse Polish stack calculator with a stack-tracking scoreboard.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rsc_pkg::*;

	localparam int         STACK_DEPTH  = STACK_DEPTH_DEF;
	localparam int         ITEM_COUNT   = 1750;
	localparam int         CYCLE_LIMIT  = 1000000;
	localparam int         DRAIN_CYCLES = 60;
	localparam int         IDLE_PCT     = 28;
	localparam int         CALM_FIRST   = 700;
	localparam int         CALM_LAST    = 1000;
	localparam logic [2:0] OP_SPARE_A   = 3'd6;
	localparam logic [2:0] OP_SPARE_B   = 3'd7;

	class calc_scoreboard;
		logic signed [DATA_W-1:0] stack_vals [STACK_DEPTH];
		int                       depth_used;
		rsp_t                     expected_answers [$];
		int                       failures;

		function new();
			depth_used = 0;
			failures   = 0;
		endfunction

		function logic signed [DATA_W-1:0] clamp(longint v, inout bit sat);
			if (v > longint'(Q_MAX)) begin
				sat = 1'b1;
				return Q_MAX;
			end
			if (v < longint'(Q_MIN)) begin
				sat = 1'b1;
				return Q_MIN;
			end
			return v[DATA_W-1:0];
		endfunction

		function void note_request(req_t req);
			longint p;
			longint q;
			longint r;
			bit     sat;
			stat_t  st;
			rsp_t   ans;
			sat = 1'b0;
			st  = STAT_OK;
			r   = 0;
			case (op_t'(req.operation))
				OP_PUSH: begin
					if (depth_used >= STACK_DEPTH) begin
						st = STAT_FULL;
					end else begin
						stack_vals[depth_used] = req.operand;
						depth_used++;
					end
				end
				OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
					if (depth_used < 2) begin
						st = STAT_EMPTY;
					end else begin
						p = stack_vals[depth_used-1];
						q = stack_vals[depth_used-2];
						case (op_t'(req.operation))
							OP_ADD: r = p + q;
							OP_SUB: r = q - p;
							OP_MUL: r = (p * q) >>> FRAC_W;
							default: begin
								if (p == 0) begin
									sat = 1'b1;
									r   = (q >= 0) ? longint'(Q_MAX) : longint'(Q_MIN);
								end else begin
									r = (q <<< FRAC_W) / p;
								end
							end
						endcase
						stack_vals[depth_used-2] = clamp(r, sat);
						depth_used--;
						if (sat) begin
							st = STAT_SAT;
						end
					end
				end
				OP_PEEK: begin
					if (depth_used == 0) begin
						st = STAT_EMPTY;
					end
				end
				default: ;
			endcase
			ans.value   = (depth_used != 0) ? stack_vals[depth_used-1] : '0;
			ans.status  = st;
			ans.entries = ENTRIES_W'(depth_used);
			expected_answers.push_back(ans);
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (expected_answers.size() == 0) begin
				$error("result with no request pending: value %h status %0d entries %0d",
					got.value, got.status, got.entries);
				failures++;
				return;
			end
			want = expected_answers.pop_front();
			if (got.value !== want.value) begin
				$error("value: expected %h, actual %h", want.value, got.value);
				failures++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				failures++;
			end
			if (got.entries !== want.entries) begin
				$error("entries: expected %0d, actual %0d", want.entries, got.entries);
				failures++;
			end
		endfunction
	endclass

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	req_t           request;
	logic           done;
	rsp_t           result;
	int             cycles = 0;
	calc_scoreboard board  = new();

	rpn_stack_calculator_unit #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("rpn_stack_calculator_unit: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			board.check_result(result);
		end
	end

	function automatic req_t make_request(logic [2:0] op, logic signed [DATA_W-1:0] val);
		req_t req;
		req.operation = op;
		req.operand   = val;
		return req;
	endfunction

	function automatic logic signed [DATA_W-1:0] random_operand();
		case ($urandom_range(9))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3: return DATA_W'($signed($urandom_range(0, 16)) - 8) <<< FRAC_W;
			4, 5: return $urandom;
			6: return DATA_W'($signed($urandom_range(0, 1048575)) - 524288);
			7: return $urandom_range(1) ? DATA_W'(1) : DATA_W'(-1);
			default: return DATA_W'($signed($urandom_range(0, 33554431)) - 16777216);
		endcase
	endfunction

	function automatic req_t random_request(int push_pct);
		logic [2:0] op;
		int         pick;
		pick = $urandom_range(99);
		if ($urandom_range(99) < push_pct) op = OP_PUSH;
		else if (pick < 20) op = OP_ADD;
		else if (pick < 40) op = OP_SUB;
		else if (pick < 60) op = OP_MUL;
		else if (pick < 80) op = OP_DIV;
		else if (pick < 94) op = OP_PEEK;
		else if (pick < 97) op = OP_SPARE_A;
		else op = OP_SPARE_B;
		return make_request(op, random_operand());
	endfunction

	// A request is held on the port until the block takes it.
	task automatic send_request(req_t req, bit may_idle);
		while (may_idle && $urandom_range(99) < IDLE_PCT) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start   <= 1'b1;
		request <= req;
		do @(posedge clk); while (busy !== 1'b0);
		board.note_request(req);
	endtask

	initial begin
		int phase_left;
		int push_pct;
		start   = 1'b0;
		request = '0;
		arst_n  = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_request(make_request(OP_PEEK, 32'h1234_5678), 1'b1);
		send_request(make_request(OP_ADD, 32'h0), 1'b1);
		send_request(make_request(OP_PUSH, Q_MAX), 1'b1);
		send_request(make_request(OP_SUB, 32'hFFFF_FFFF), 1'b1);
		send_request(make_request(OP_PUSH, Q_MAX), 1'b1);
		send_request(make_request(OP_ADD, 32'h0), 1'b1);
		send_request(make_request(OP_PUSH, Q_MIN), 1'b1);
		send_request(make_request(OP_SUB, 32'h0), 1'b1);
		send_request(make_request(OP_PUSH, 32'h0002_0000), 1'b1);
		send_request(make_request(OP_MUL, 32'h0), 1'b1);
		send_request(make_request(OP_PUSH, 32'h0), 1'b1);
		send_request(make_request(OP_DIV, 32'h0), 1'b1);
		send_request(make_request(OP_PUSH, Q_MIN), 1'b1);
		send_request(make_request(OP_PUSH, 32'h0), 1'b1);
		send_request(make_request(OP_DIV, 32'h0), 1'b1);
		send_request(make_request(OP_PUSH, 32'hFFFF_FFFF), 1'b1);
		send_request(make_request(OP_PUSH, 32'h0000_8000), 1'b1);
		send_request(make_request(OP_MUL, 32'h0), 1'b1);
		send_request(make_request(OP_PUSH, 32'h0003_0000), 1'b1);
		send_request(make_request(OP_PUSH, 32'hFFFE_0000), 1'b1);
		send_request(make_request(OP_DIV, 32'h0), 1'b1);
		send_request(make_request(OP_PUSH, 32'h0003_0000), 1'b1);
		send_request(make_request(OP_DIV, 32'h0), 1'b1);
		send_request(make_request(OP_PEEK, 32'h0), 1'b1);
		send_request(make_request(OP_SPARE_A, 32'hFFFF_FFFF), 1'b1);
		send_request(make_request(OP_SPARE_B, 32'h0), 1'b1);

		phase_left = 120;
		push_pct   = 90;
		for (int i = 0; i < ITEM_COUNT; i++) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(20, 120);
				case ($urandom_range(2))
					0: push_pct = 85;
					1: push_pct = 50;
					default: push_pct = 20;
				endcase
			end
			send_request(random_request(push_pct), !(i >= CALM_FIRST && i < CALM_LAST));
			phase_left--;
		end
		@(negedge clk);
		start <= 1'b0;

		while (board.expected_answers.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.failures == 0) begin
			$display("rpn_stack_calculator_unit: match");
		end else begin
			$display("rpn_stack_calculator_unit: mismatch");
		end
		$finish;
	end

endmodule
